// ===== rtl/core/lru_pkg.sv =====
// ----------------------------------------------------------------------------
// LRU page replacement package
// Shared sizes, word types, the controller state type and the command struct.
// ----------------------------------------------------------------------------
package lru_pkg;

    // Number of physical frames.
    localparam int FRAMES = 16;
    // Width of a frame index and of a recency rank.
    localparam int SLOT_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    // Width of a count of frames from zero up to FRAMES.
    localparam int CNT_W  = $clog2(FRAMES + 1);
    // Width used to compare the frame count against the clamped limit.
    localparam int LIM_W  = 8;

    localparam logic [4:0]  LIMIT_RESET = 5'd4;
    localparam logic [15:0] FAULT_MAX   = 16'hFFFF;

    // One page reference.
    typedef struct packed {
        logic [7:0] page;
        logic       last_of_sequence;
    } req_word_t;

    // One lookup result.
    typedef struct packed {
        logic        hit;
        logic [3:0]  frame_slot;
        logic        evicted_valid;
        logic [7:0]  evicted_page;
        logic [15:0] fault_total;
        logic [4:0]  frames_used;
    } rsp_word_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_COMMIT
    } lru_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic eval;
        logic commit;
    } lru_cmd_t;

endpackage

// ===== rtl/core/lru_page_replacement.sv =====
// Each reference passes through accept, parallel match and rank commit before a result
// word becomes valid; a new reference is accepted only after the previous commit, and
// a commit waits only while the previous result is still untaken.
// Reset: frame_limit returns to 4, frame count and fault total clear; the frame
// store and ranks have no reset and no clearing pass is needed.
// ----------------------------------------------------------------------------
// LRU page replacement top level
// Joins the sequencing controller with the frame datapath.
// ----------------------------------------------------------------------------
module lru_page_replacement
    import lru_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  req_word_t  req,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    output rsp_word_t  rsp,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [4:0] cfg_data
);

    lru_cmd_t cmd;

    // The limit register takes a write in any cycle.
    assign cfg_ready = 1'b1;

    lru_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cmd       (cmd)
    );

    lru_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .req      (req),
        .cfg_we   (cfg_valid),
        .cfg_data (cfg_data),
        .rsp      (rsp)
    );

endmodule

// ===== rtl/core/lru_datapath.sv =====
// ----------------------------------------------------------------------------
// LRU page replacement datapath
// Frame store, recency ranks, counters, limit register and result register.
// ----------------------------------------------------------------------------
module lru_datapath
    import lru_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  lru_cmd_t   cmd,
    input  req_word_t  req,
    input  logic       cfg_we,
    input  logic [4:0] cfg_data,
    output rsp_word_t  rsp
);

    // Latched reference.
    logic [7:0]         page_reg;
    logic               last_reg;

    // Frame contents and recency ranks; entries at or above the count are unused.
    logic [7:0]         frame_page_reg [FRAMES];
    logic [SLOT_W-1:0]  rank_reg       [FRAMES];

    logic [CNT_W-1:0]   used_reg;
    logic [CNT_W-1:0]   used_next;
    logic [15:0]        fault_reg;
    logic [15:0]        fault_next;
    logic [4:0]         limit_reg;

    // Results of the lookup cycle.
    logic               hit_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic               evict_reg;
    logic               fill_reg;
    logic [7:0]         evpage_reg;
    logic [SLOT_W-1:0]  below_reg;
    logic               age_all_reg;

    rsp_word_t          rsp_reg;

    // Lookup logic.
    logic               match_any;
    logic [SLOT_W-1:0]  match_slot;
    logic [SLOT_W-1:0]  lru_slot;
    logic [SLOT_W-1:0]  oldest_rank;
    logic [LIM_W-1:0]   limit_eff;
    logic               room;

    assign oldest_rank = SLOT_W'(used_reg - CNT_W'(1));

    // Clamp the limit to the range one to FRAMES.
    always_comb
    begin
        limit_eff = LIM_W'(limit_reg);
        if (limit_eff == '0)
        begin
            limit_eff = LIM_W'(1);
        end
        if (limit_eff > LIM_W'(FRAMES))
        begin
            limit_eff = LIM_W'(FRAMES);
        end
    end

    assign room = (LIM_W'(used_reg) < limit_eff);

    // Parallel match against used frames; resident pages are unique, so an OR encode is enough.
    always_comb
    begin
        match_any  = 1'b0;
        match_slot = '0;
        lru_slot   = '0;
        for (int j = 0; j < FRAMES; j++)
        begin
            if ((CNT_W'(j) < used_reg) && (frame_page_reg[j] == page_reg))
            begin
                match_any  = 1'b1;
                match_slot = match_slot | SLOT_W'(j);
            end
            if ((CNT_W'(j) < used_reg) && (rank_reg[j] == oldest_rank))
            begin
                lru_slot = lru_slot | SLOT_W'(j);
            end
        end
    end

    // Count and fault total after the commit.
    always_comb
    begin
        used_next  = used_reg;
        fault_next = fault_reg;
        if (!hit_reg)
        begin
            if (fault_reg != FAULT_MAX)
            begin
                fault_next = fault_reg + 16'd1;
            end
            if (fill_reg)
            begin
                used_next = used_reg + CNT_W'(1);
            end
        end
    end

    // Control registers: counts and frame limit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg  <= '0;
            fault_reg <= '0;
            limit_reg <= LIMIT_RESET;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_data;
            end
            if (cmd.commit)
            begin
                if (last_reg)
                begin
                    used_reg  <= '0;
                    fault_reg <= '0;
                end
                else
                begin
                    used_reg  <= used_next;
                    fault_reg <= fault_next;
                end
            end
        end
    end

    // Payload registers: latched input, lookup results, frames and result word.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            page_reg <= req.page;
            last_reg <= req.last_of_sequence;
        end
        if (cmd.eval)
        begin
            hit_reg     <= match_any;
            fill_reg    <= !match_any && room;
            evict_reg   <= !match_any && !room;
            age_all_reg <= !match_any;
            below_reg   <= rank_reg[match_slot];
            if (match_any)
            begin
                slot_reg <= match_slot;
            end
            else if (room)
            begin
                slot_reg <= SLOT_W'(used_reg);
            end
            else
            begin
                slot_reg <= lru_slot;
            end
            evpage_reg <= (!match_any && !room) ? frame_page_reg[lru_slot] : 8'd0;
        end
        if (cmd.commit)
        begin
            // Age the used frames that were more recent than the referenced one, or all used frames on a miss.
            for (int j = 0; j < FRAMES; j++)
            begin
                if (SLOT_W'(j) == slot_reg)
                begin
                    rank_reg[j] <= '0;
                end
                else if ((CNT_W'(j) < used_reg) && (age_all_reg || (rank_reg[j] < below_reg)))
                begin
                    rank_reg[j] <= rank_reg[j] + SLOT_W'(1);
                end
            end
            if (!hit_reg)
            begin
                frame_page_reg[slot_reg] <= page_reg;
            end
            rsp_reg.hit           <= hit_reg;
            rsp_reg.frame_slot    <= 4'(slot_reg);
            rsp_reg.evicted_valid <= evict_reg;
            rsp_reg.evicted_page  <= evpage_reg;
            rsp_reg.fault_total   <= fault_next;
            rsp_reg.frames_used   <= 5'(used_next);
        end
    end

    assign rsp = rsp_reg;

endmodule

// ===== rtl/core/lru_controller.sv =====
// ----------------------------------------------------------------------------
// LRU page replacement controller
// Sequences load, lookup and commit and owns the result valid flag.
// ----------------------------------------------------------------------------
module lru_controller
    import lru_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output lru_cmd_t cmd
);

    lru_state_t state_reg;
    lru_state_t state_next;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;

    // State and result valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Next state and commands. The commit waits until the result register is free or its word is being taken.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_MATCH;
                end
            end
            ST_MATCH:
            begin
                cmd.eval   = 1'b1;
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // A word waits in the result register until it is taken.
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (cmd.commit)
        begin
            rsp_valid_next = 1'b1;
        end
    end

    assign rsp_valid = rsp_valid_reg;

`ifndef SYNTH
    a_load_to_match: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == ST_MATCH))
        else $error("accepted word did not enter lookup");
    a_match_to_commit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MATCH) |=> (state_reg == ST_COMMIT))
        else $error("lookup not followed by commit");
    a_commit_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> (rsp_valid && (state_reg == ST_IDLE)))
        else $error("commit did not present a result");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && rsp_valid_reg) |-> rsp_ready)
        else $error("result overwritten before it was taken");
`endif

endmodule
